[hdl/krp_pkg.sv]
// Shared widths, constants and handshake structs for the key range partitioner.
// Used by krp_divider, key_range_partitioner and the tests; depends on nothing else.
`timescale 1ns / 1ps

package krp_pkg;

  localparam int unsigned TagW    = 8;   // table tag
  localparam int unsigned KeyW    = 48;  // key space, chunk and key bounds
  localparam int unsigned ChunkW  = 31;  // chunk length
  localparam int unsigned CfgW    = 7;   // server count register
  localparam int unsigned IdxW    = 6;   // server index
  localparam int unsigned AccW    = KeyW + 1;  // chunk * length stays below 2^49

  localparam int unsigned MaxServers = 64;

  // Divider: dividend of KeyW bits, divisor of ChunkW bits, one quotient bit per cycle
  localparam int unsigned DivSteps = KeyW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned DivRemW  = ChunkW + 1;

  // Multiplier: one multiplier bit per cycle over the chunk length
  localparam int unsigned MulSteps = ChunkW;
  localparam int unsigned MulCntW  = $clog2(MulSteps);

  typedef struct packed {
    logic              start;
    logic [KeyW-1:0]   dividend;
    logic [ChunkW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [KeyW-1:0]   quotient;
    logic [ChunkW-1:0] remainder;
  } div_rsp_t;

endpackage

[hdl/krp_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle; a new start restarts it.
// Depends on krp_pkg for widths and the request / response structs.
`timescale 1ns / 1ps

module krp_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  krp_pkg::div_req_t req_i,
  output krp_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [krp_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [krp_pkg::KeyW-1:0]      quo_q, quo_d;
  logic [krp_pkg::DivRemW-1:0]   rem_q, rem_d;
  logic [krp_pkg::ChunkW-1:0]    dvs_q, dvs_d;
  logic [krp_pkg::DivRemW-1:0]   trial;
  logic                          qbit;

  // Load operands on start, else shift in the next dividend bit and try one subtract
  always_comb begin
    trial = {rem_q[krp_pkg::DivRemW-2:0], quo_q[krp_pkg::KeyW-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = qbit ? (trial - {1'b0, dvs_q}) : trial;
      quo_d = {quo_q[krp_pkg::KeyW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == krp_pkg::DivCntW'(krp_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset; datapath needs none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[krp_pkg::ChunkW-1:0];

  // Remainder always stays below the divisor between steps
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start |=> rem_q < {1'b0, dvs_q})
    else $error("divider remainder not below divisor");

  // Done never coincides with a running division
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

endmodule

[hdl/key_range_partitioner.sv]
// Key range partitioner: splits ceil(K / C) chunks over S servers, one result per server.
// Steps: two bit-serial divisions on the shared divider and a bit-serial multiply, then
// one result per cycle while the result channel takes them.
// A new request is taken only in idle, once the last result of the one before is sent.
// Reset: asynchronous active low; server count returns to 1 and all handshakes go idle.
// Depends on krp_pkg and krp_divider.
`timescale 1ns / 1ps

module key_range_partitioner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         server_count_we_i,
  input  logic [krp_pkg::CfgW-1:0]     server_count_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [krp_pkg::TagW-1:0]     table_id_i,
  input  logic [krp_pkg::KeyW-1:0]     key_space_i,
  input  logic [krp_pkg::ChunkW-1:0]   chunk_length_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [krp_pkg::TagW-1:0]     table_tag_o,
  output logic [krp_pkg::IdxW-1:0]     server_index_o,
  output logic [krp_pkg::KeyW-1:0]     chunk_first_o,
  output logic [krp_pkg::KeyW-1:0]     chunk_limit_o,
  output logic [krp_pkg::KeyW-1:0]     key_first_o,
  output logic [krp_pkg::KeyW-1:0]     key_limit_o,
  output logic                         is_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_N,
    ST_DIV_S,
    ST_MUL,
    ST_PREP,
    ST_EMIT
  } state_e;

  state_e                         state_q;
  logic [krp_pkg::CfgW-1:0]       server_count_q;

  // request context
  logic [krp_pkg::TagW-1:0]       tag_q;
  logic [krp_pkg::KeyW-1:0]       keys_q;
  logic [krp_pkg::ChunkW-1:0]     clen_q;
  logic [krp_pkg::CfgW-1:0]       srv_q;
  logic [krp_pkg::IdxW-1:0]       srv_last_q;
  logic                           keys_zero_q;

  // division results
  logic [krp_pkg::KeyW-1:0]       nchunks_q;
  logic [krp_pkg::KeyW-1:0]       base_q;
  logic [krp_pkg::CfgW-1:0]       rem_n_q;

  // serial multiplier base * C
  logic [krp_pkg::AccW-1:0]       mcand_q;
  logic [krp_pkg::ChunkW-1:0]     mplier_q;
  logic [krp_pkg::AccW-1:0]       prod_q;
  logic [krp_pkg::MulCntW-1:0]    mul_cnt_q;
  logic [krp_pkg::AccW-1:0]       step_hi_q;

  // per-server walk
  logic [krp_pkg::IdxW-1:0]       idx_q;
  logic [krp_pkg::KeyW-1:0]       first_q;
  logic [krp_pkg::AccW-1:0]       key_acc_q;

  // result register
  logic                           out_valid_q;
  logic [krp_pkg::TagW-1:0]       table_tag_q;
  logic [krp_pkg::IdxW-1:0]       server_index_q;
  logic [krp_pkg::KeyW-1:0]       chunk_first_q;
  logic [krp_pkg::KeyW-1:0]       chunk_limit_q;
  logic [krp_pkg::KeyW-1:0]       key_first_q;
  logic [krp_pkg::KeyW-1:0]       key_limit_q;
  logic                           is_last_q;

  krp_pkg::div_req_t              div_req;
  krp_pkg::div_rsp_t              div_rsp;

  logic                           in_fire;
  logic                           emit_fire;
  logic [krp_pkg::ChunkW-1:0]     clen_fix;
  logic [krp_pkg::CfgW-1:0]       srv_fix;
  logic [krp_pkg::KeyW-1:0]       nchunks_c;
  logic                           extra;
  logic                           last_c;
  logic [krp_pkg::KeyW-1:0]       limit_c;
  logic [krp_pkg::AccW-1:0]       key_lim_acc;
  logic [krp_pkg::KeyW-1:0]       key_first_c;
  logic [krp_pkg::KeyW-1:0]       key_limit_c;

  krp_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // Clean up the operands: zero length acts as one, server count saturates to 1..64
  always_comb begin
    clen_fix = (chunk_length_i == '0) ? krp_pkg::ChunkW'(1) : chunk_length_i;
    if (server_count_q == '0) begin
      srv_fix = krp_pkg::CfgW'(1);
    end else if (server_count_q > krp_pkg::CfgW'(krp_pkg::MaxServers)) begin
      srv_fix = krp_pkg::CfgW'(krp_pkg::MaxServers);
    end else begin
      srv_fix = server_count_q;
    end
  end

  // Chunk count from the first division
  assign nchunks_c = keys_zero_q ? '0 : (div_rsp.quotient + krp_pkg::KeyW'(1));

  // Drive the shared divider: (K - 1) / C first, then N / S
  always_comb begin
    div_req = '0;
    if (in_fire) begin
      div_req.start    = 1'b1;
      div_req.dividend = key_space_i - krp_pkg::KeyW'(1);
      div_req.divisor  = clen_fix;
    end else if (state_q == ST_DIV_N && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = nchunks_c;
      div_req.divisor  = krp_pkg::ChunkW'(srv_q);
    end
  end

  // Next server's ranges: advance by base chunks, one more while below the remainder
  always_comb begin
    extra       = ({1'b0, idx_q} < rem_n_q);
    last_c      = (idx_q == srv_last_q);
    limit_c     = last_c ? nchunks_q
                         : (first_q + base_q + krp_pkg::KeyW'(extra));
    key_lim_acc = key_acc_q + (extra ? step_hi_q : prod_q);
    key_first_c = (first_q >= nchunks_q) ? keys_q : key_acc_q[krp_pkg::KeyW-1:0];
    key_limit_c = (limit_c >= nchunks_q) ? keys_q : key_lim_acc[krp_pkg::KeyW-1:0];
  end

  // Write the server count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q <= krp_pkg::CfgW'(1);
    end else if (server_count_we_i) begin
      server_count_q <= server_count_i;
    end
  end

  // Sequence one request: divide, divide, multiply, then walk the servers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_DIV_N;
          end
        end
        ST_DIV_N: begin
          if (div_rsp.done) begin
            state_q <= ST_DIV_S;
          end
        end
        ST_DIV_S: begin
          if (div_rsp.done) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_cnt_q == krp_pkg::MulCntW'(krp_pkg::MulSteps - 1)) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire && last_c) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: loaded under the state machine, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tag_q       <= table_id_i;
      keys_q      <= key_space_i;
      keys_zero_q <= (key_space_i == '0);
      clen_q      <= clen_fix;
      srv_q       <= srv_fix;
      srv_last_q  <= krp_pkg::IdxW'(srv_fix - krp_pkg::CfgW'(1));
    end
    if (state_q == ST_DIV_N && div_rsp.done) begin
      nchunks_q <= nchunks_c;
    end
    if (state_q == ST_DIV_S && div_rsp.done) begin
      base_q    <= div_rsp.quotient;
      rem_n_q   <= krp_pkg::CfgW'(div_rsp.remainder);
      mcand_q   <= krp_pkg::AccW'(div_rsp.quotient);
      mplier_q  <= clen_q;
      prod_q    <= '0;
      mul_cnt_q <= '0;
    end
    // Shift-add one multiplier bit per cycle
    if (state_q == ST_MUL) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q   <= {mcand_q[krp_pkg::AccW-2:0], 1'b0};
      mplier_q  <= {1'b0, mplier_q[krp_pkg::ChunkW-1:1]};
      mul_cnt_q <= mul_cnt_q + 1'b1;
    end
    if (state_q == ST_PREP) begin
      step_hi_q <= prod_q + krp_pkg::AccW'(clen_q);
      idx_q     <= '0;
      first_q   <= '0;
      key_acc_q <= '0;
    end
    if (emit_fire) begin
      table_tag_q    <= tag_q;
      server_index_q <= idx_q;
      chunk_first_q  <= first_q;
      chunk_limit_q  <= limit_c;
      key_first_q    <= key_first_c;
      key_limit_q    <= key_limit_c;
      is_last_q      <= last_c;
      idx_q          <= idx_q + 1'b1;
      first_q        <= limit_c;
      key_acc_q      <= key_lim_acc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign table_tag_o    = table_tag_q;
  assign server_index_o = server_index_q;
  assign chunk_first_o  = chunk_first_q;
  assign chunk_limit_o  = chunk_limit_q;
  assign key_first_o    = key_first_q;
  assign key_limit_o    = key_limit_q;
  assign is_last_o      = is_last_q;

  // Divider answers only while a division is expected
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_N || state_q == ST_DIV_S))
    else $error("divider done outside a division state");

  // Chunk ranges never run backward
  a_chunk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chunk_limit_o >= chunk_first_o)
    else $error("chunk limit below chunk first");

  // Key ranges never run backward
  a_key_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_limit_o >= key_first_o)
    else $error("key limit below key first");

  // A walk always starts at server zero with chunk zero
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PREP |=> idx_q == '0 && first_q == '0)
    else $error("server walk did not start at zero");

endmodule

[test/krp_partition_checker.sv]
// Partition checker: watches the request, result and server count ports of the
// key range partitioner, predicts every server range and compares. Depends on krp_pkg.
`timescale 1ns / 1ps

module krp_partition_checker
  import krp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              server_count_we_i,
  input  logic [CfgW-1:0]   server_count_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [TagW-1:0]   table_id_i,
  input  logic [KeyW-1:0]   key_space_i,
  input  logic [ChunkW-1:0] chunk_length_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [TagW-1:0]   table_tag_i,
  input  logic [IdxW-1:0]   server_index_i,
  input  logic [KeyW-1:0]   chunk_first_i,
  input  logic [KeyW-1:0]   chunk_limit_i,
  input  logic [KeyW-1:0]   key_first_i,
  input  logic [KeyW-1:0]   key_limit_i,
  input  logic              is_last_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [IdxW-1:0] server;
    logic [KeyW-1:0] chunk_first;
    logic [KeyW-1:0] chunk_limit;
    logic [KeyW-1:0] key_first;
    logic [KeyW-1:0] key_limit;
    logic            last;
  } server_range_t;

  server_range_t   expected_ranges[$];
  logic [CfgW-1:0] servers_q;
  int unsigned     mismatches;

  assign mismatch_count_o = mismatches;

  // Map a chunk bound to a key bound; bounds at or past the chunk count clamp to K
  function automatic logic [KeyW-1:0] chunk_to_key(input logic [63:0] chunk,
                                                   input logic [63:0] nchunks,
                                                   input logic [63:0] clen,
                                                   input logic [63:0] keys);
    logic [63:0] prod;
    prod = chunk * clen;
    if (chunk >= nchunks) return keys[KeyW-1:0];
    return prod[KeyW-1:0];
  endfunction

  // Deal the chunks of one request over the servers and queue one range per server
  task automatic predict_split(input logic [TagW-1:0]   tag,
                               input logic [KeyW-1:0]   keys_in,
                               input logic [ChunkW-1:0] len_in);
    logic [63:0]   s, keys, clen, nchunks, base, rem, first, limit, i;
    server_range_t rec;
    s = 64'(servers_q);
    if (s == 0) s = 64'd1;
    if (s > 64'(MaxServers)) s = 64'(MaxServers);
    keys = 64'(keys_in);
    clen = (len_in == 0) ? 64'd1 : 64'(len_in);
    nchunks = (keys == 0) ? 64'd0 : (keys - 1) / clen + 1;
    base = nchunks / s;
    rem = nchunks % s;
    for (i = 0; i < s; i++) begin
      if (i < rem) begin
        first = i * (base + 1);
        limit = first + base + 1;
      end else begin
        first = rem * (base + 1) + (i - rem) * base;
        limit = first + base;
      end
      if (i == s - 1) limit = nchunks;
      rec.tag         = tag;
      rec.server      = i[IdxW-1:0];
      rec.chunk_first = first[KeyW-1:0];
      rec.chunk_limit = limit[KeyW-1:0];
      rec.key_first   = chunk_to_key(first, nchunks, clen, keys);
      rec.key_limit   = chunk_to_key(limit, nchunks, clen, keys);
      rec.last        = (i == s - 1);
      expected_ranges = {expected_ranges, rec};
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Match one delivered range against the oldest prediction
  task automatic check_range();
    server_range_t want;
    if (expected_ranges.size() == 0) begin
      mismatches++;
      $display("%0t: result expected none, got table_tag %0d server_index %0d",
               $time, table_tag_i, server_index_i);
      return;
    end
    want = expected_ranges.pop_front();
    compare_field("table_tag", 64'(want.tag), 64'(table_tag_i));
    compare_field("server_index", 64'(want.server), 64'(server_index_i));
    compare_field("chunk_first", 64'(want.chunk_first), 64'(chunk_first_i));
    compare_field("chunk_limit", 64'(want.chunk_limit), 64'(chunk_limit_i));
    compare_field("key_first", 64'(want.key_first), 64'(key_first_i));
    compare_field("key_limit", 64'(want.key_limit), 64'(key_limit_i));
    compare_field("is_last", 64'(want.last), 64'(is_last_i));
  endtask

  // Sample both channels and the register port at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_ranges.delete();
      mismatches = 0;
      servers_q <= CfgW'(1);
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_range();
      if (in_valid_i && in_ready_i) predict_split(table_id_i, key_space_i, chunk_length_i);
      if (server_count_we_i) servers_q <= server_count_i;
      pending_o <= expected_ranges.size();
    end
  end

endmodule

[test/tb_key_range_partitioner.sv]
// Top of the key range partitioner test: clock, reset, request and result traffic,
// server count writes and the verdict. Depends on krp_pkg and krp_partition_checker.
`timescale 1ns / 1ps

module tb_key_range_partitioner;
  import krp_pkg::*;

  localparam int unsigned HoldCycles  = 1000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned Blocks      = 10;
  localparam int unsigned PerBlock    = 30;
  localparam logic [KeyW-1:0]   KeyMax   = '1;
  localparam logic [ChunkW-1:0] ChunkMax = '1;

  logic              clk;
  logic              rst_n;
  logic              server_count_we;
  logic [CfgW-1:0]   server_count;
  logic              in_valid;
  logic              in_ready;
  logic [TagW-1:0]   table_id;
  logic [KeyW-1:0]   key_space;
  logic [ChunkW-1:0] chunk_length;
  logic              out_valid;
  logic              out_ready;
  logic [TagW-1:0]   table_tag;
  logic [IdxW-1:0]   server_index;
  logic [KeyW-1:0]   chunk_first;
  logic [KeyW-1:0]   chunk_limit;
  logic [KeyW-1:0]   key_first;
  logic [KeyW-1:0]   key_limit;
  logic              is_last;
  int unsigned       mismatch_count;
  int unsigned       pending;
  bit                hold_req;
  bit                steady;

  key_range_partitioner dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .server_count_we_i (server_count_we),
    .server_count_i    (server_count),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .table_id_i        (table_id),
    .key_space_i       (key_space),
    .chunk_length_i    (chunk_length),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .table_tag_o       (table_tag),
    .server_index_o    (server_index),
    .chunk_first_o     (chunk_first),
    .chunk_limit_o     (chunk_limit),
    .key_first_o       (key_first),
    .key_limit_o       (key_limit),
    .is_last_o         (is_last)
  );

  krp_partition_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .server_count_we_i (server_count_we),
    .server_count_i    (server_count),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .table_id_i        (table_id),
    .key_space_i       (key_space),
    .chunk_length_i    (chunk_length),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .table_tag_i       (table_tag),
    .server_index_i    (server_index),
    .chunk_first_i     (chunk_first),
    .chunk_limit_i     (chunk_limit),
    .key_first_i       (key_first),
    .key_limit_i       (key_limit),
    .is_last_i         (is_last),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 8);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [KeyW-1:0] rand_keys();
    logic [63:0] v;
    int unsigned r;
    v = {$urandom(), $urandom()};
    v = v & 64'(KeyMax);
    r = $urandom_range(0, 19);
    if (r < 4) return KeyW'($urandom_range(1, 2000));
    if (r < 11) v = v >> $urandom_range(0, KeyW - 1);
    else if (r == 18) return KeyMax;
    else if (r == 19) return '0;
    if (v == 0) v = 1;
    return v[KeyW-1:0];
  endfunction

  function automatic logic [ChunkW-1:0] rand_chunk();
    logic [31:0] v;
    int unsigned r;
    v = $urandom() & 32'(ChunkMax);
    r = $urandom_range(0, 19);
    if (r < 8) return ChunkW'($urandom_range(1, 16));
    if (r < 16) v = v >> $urandom_range(0, ChunkW - 1);
    else if (r == 18) return ChunkMax;
    else if (r == 19) return '0;
    if (v == 0) v = 1;
    return v[ChunkW-1:0];
  endfunction

  function automatic logic [CfgW-1:0] rand_servers();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return CfgW'($urandom_range(1, 8));
    if (r < 8) return CfgW'($urandom_range(9, 64));
    if (r == 8) return CfgW'(MaxServers);
    return CfgW'($urandom_range(0, 127));
  endfunction

  // Offer one request and hold it until taken, then idle at random
  task automatic send_request(input logic [TagW-1:0] tag, input logic [KeyW-1:0] keys,
                              input logic [ChunkW-1:0] clen);
    int unsigned gap;
    in_valid     <= 1'b1;
    table_id     <= tag;
    key_space    <= keys;
    chunk_length <= clen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = (!steady && $urandom_range(0, 1) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted range has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_servers(input logic [CfgW-1:0] n);
    wait_idle();
    server_count_we <= 1'b1;
    server_count    <= n;
    @(posedge clk);
    server_count_we <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    bit          held;
    stall = 0;
    held  = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        held = 1'b1;
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  // Request side and verdict
  initial begin
    int unsigned blk;
    int unsigned k;
    rst_n           = 1'b0;
    server_count_we = 1'b0;
    server_count    = '0;
    in_valid        = 1'b0;
    table_id        = '0;
    key_space       = '0;
    chunk_length    = '0;
    hold_req        = 1'b0;
    steady          = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single server after reset: field extremes, empty key space, zero chunk length
    send_request(8'h00, 48'd1, 31'd1);
    send_request(8'hFF, KeyMax, 31'd1);
    send_request(8'h5A, KeyMax, ChunkMax);
    send_request(8'h01, '0, 31'd5);
    send_request(8'h02, 48'd100, '0);

    // Full server count: fewer chunks than servers, even and uneven splits
    set_servers(CfgW'(MaxServers));
    send_request(8'h10, 48'd10, 31'd3);
    send_request(8'h11, KeyMax, 31'd1);
    send_request(8'h12, '0, 31'd1);
    send_request(8'h13, 48'd6400, 31'd100);
    send_request(8'h14, 48'd6465, 31'd100);
    send_request(8'hA5, KeyMax, ChunkMax);

    // Zero server count acts as one server
    set_servers('0);
    send_request(8'h20, 48'd77, 31'd7);

    // Counts above the maximum saturate
    set_servers('1);
    send_request(8'h30, 48'd1000, 31'd3);
    set_servers(CfgW'(MaxServers + 1));
    send_request(8'h31, 48'd129, 31'd1);

    // Three servers: remainders of one and two, a short tail chunk
    set_servers(CfgW'(3));
    send_request(8'h40, 48'd10, 31'd1);
    send_request(8'h41, 48'd11, 31'd1);
    send_request(8'h42, 48'd2, 31'd1);
    send_request(8'h43, 48'd10, 31'd4);

    // Random blocks, each under its own server count
    for (blk = 0; blk < Blocks; blk++) begin
      set_servers(blk == 0 ? CfgW'(MaxServers) : rand_servers());
      steady = (blk == 5);
      if (blk == 2) hold_req = 1'b1;
      for (k = 0; k < PerBlock; k++) begin
        send_request(TagW'($urandom_range(0, 255)), rand_keys(), rand_chunk());
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/krp_pkg.sv
hdl/krp_divider.sv
hdl/key_range_partitioner.sv
test/krp_partition_checker.sv
test/tb_key_range_partitioner.sv
